// ===== hw/rtl/filtered_descending_insertion_sort_top_assert.svh =====
// Assertion macros shared by the filtered descending insertion sort RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef FILTERED_DESCENDING_INSERTION_SORT_TOP_ASSERT_SVH
`define FILTERED_DESCENDING_INSERTION_SORT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset
`define FDIS_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same-cycle implication
`define FDIS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define FDIS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FDIS_ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define FDIS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define FDIS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/fdis_pkg.sv =====
// Types and constants of the filtered descending insertion sort.
// Used by fdis_ctrl and the top level; depends on nothing.
package fdis_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int ID_W             = 31;
   localparam int GROUP_W          = 16;
   localparam int SCORE_W          = 16;

   localparam logic STATUS_SORTED = 1'b0;
   localparam logic STATUS_EMPTY  = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]    record_id;
      logic [GROUP_W-1:0] group_code;
      logic [SCORE_W-1:0] score;
      logic               final_record;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    out_id;
      logic [SCORE_W-1:0] out_score;
      logic               status;
      logic               overflowed;
      logic               last_result;
   } rsp_type;

   // One stored entry
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] score;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Result handed from the sequencer to the output register
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } evt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_EMIT,
      ST_FLUSH
   } state_type;

endpackage

// ===== hw/rtl/fdis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fdis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fdis_ctrl.sv =====
// Sequencer of the sort: filters items, shifts entries in the store RAM and drains it.
// Depends on fdis_pkg, fdis_ram and the assertion macro header.
`include "filtered_descending_insertion_sort_top_assert.svh"
module fdis_ctrl import fdis_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  req_type            req_item,
   input  logic [GROUP_W-1:0] wanted_group,
   output logic               busy,
   output evt_type            evt
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            drop_ff, drop_in;
   entry_type       new_ff, new_in;
   logic            fin_ff, fin_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [AW-1:0]   ptr_ff, ptr_in;
   logic            pend_valid_ff, pend_valid_in;
   logic            pend_last_ff, pend_last_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   entry_type          wr_data;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type          rd_entry;
   entry_type          req_entry;
   logic               full;
   logic [AW-1:0]      tail;

   // Store of sorted entries
   fdis_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry  = entry_type'(rd_raw);
   assign req_entry = '{id: req_item.record_id, score: req_item.score};
   assign full      = (count_ff == CW'(CAPACITY));
   // index of the last valid entry; only used while count is 1..CAPACITY
   assign tail      = AW'(count_ff - CW'(1));
   assign busy      = (state_ff != ST_IDLE);

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         drop_ff       <= 1'b0;
         fin_ff        <= 1'b0;
         ptr_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         drop_ff       <= drop_in;
         fin_ff        <= fin_in;
         ptr_ff        <= ptr_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      new_ff       <= new_in;
      idx_ff       <= idx_in;
      pend_last_ff <= pend_last_in;
   end

   // Next state, RAM access and result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      drop_in       = drop_ff;
      new_in        = new_ff;
      fin_in        = fin_ff;
      idx_in        = idx_ff;
      ptr_in        = '0;
      pend_valid_in = 1'b0;
      pend_last_in  = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = new_ff;
      rd_addr       = ptr_ff;

      // drained entry whose read was issued last cycle
      evt.valid           = pend_valid_ff;
      evt.rsp.out_id      = rd_entry.id;
      evt.rsp.out_score   = rd_entry.score;
      evt.rsp.status      = STATUS_SORTED;
      evt.rsp.overflowed  = drop_ff;
      evt.rsp.last_result = pend_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               new_in = req_entry;
               fin_in = req_item.final_record;
               state_in = req_item.final_record ? ST_EMIT : ST_IDLE;
               if (req_item.group_code == wanted_group) begin
                  if (full) begin
                     drop_in = 1'b1;
                  end else if (count_ff == '0) begin
                     // empty store: write straight into the head
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = req_entry;
                     count_in = count_ff + CW'(1);
                  end else begin
                     // walk down from the tail
                     rd_addr  = tail;
                     idx_in   = tail;
                     state_in = ST_SHIFT;
                  end
               end
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + AW'(1);
            if (rd_entry.score < new_ff.score) begin
               // move the entry one place down, keep walking
               wr_data = rd_entry;
               if (idx_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_addr = idx_ff - AW'(1);
                  idx_in  = idx_ff - AW'(1);
               end
            end else begin
               // equal or higher score stays ahead: new item goes right after
               wr_data  = new_ff;
               count_in = count_ff + CW'(1);
               state_in = fin_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = new_ff;
            count_in = count_ff + CW'(1);
            state_in = fin_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (count_ff == '0) begin
               evt.valid           = 1'b1;
               evt.rsp.out_id      = '0;
               evt.rsp.out_score   = '0;
               evt.rsp.status      = STATUS_EMPTY;
               evt.rsp.overflowed  = drop_ff;
               evt.rsp.last_result = 1'b1;
               drop_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               rd_addr       = ptr_ff;
               pend_valid_in = 1'b1;
               pend_last_in  = (ptr_ff == tail);
               ptr_in        = ptr_ff + AW'(1);
               if (ptr_ff == tail) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            // last drained entry goes out now; the run ends
            count_in = '0;
            drop_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `FDIS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `FDIS_ASSERT_IMPLIES(a_no_write_drain, clock, reset, state_ff == ST_EMIT || state_ff == ST_FLUSH, !wr_en, "store written while draining")
   `FDIS_ASSERT_IMPLIES(a_shift_room, clock, reset, state_ff == ST_SHIFT, count_ff != '0 && !full, "shift without room")
   `FDIS_ASSERT_NEXT(a_run_ends, clock, reset, evt.valid && evt.rsp.last_result, state_ff == ST_IDLE && count_ff == '0 && !drop_ff, "run not cleared after last result")

endmodule

// ===== hw/rtl/filtered_descending_insertion_sort_top.sv =====
// Top level of the filtered descending insertion sort.
// Depends on fdis_pkg, fdis_ctrl and the assertion macro header.
//
// Records enter on start while busy is low. A record of another group, one
// dropped because the store holds CAPACITY entries, or a matching record that
// finds the store empty is taken without a walk. Any other matching record
// walks the sorted store from its tail, one entry per cycle through the single
// read port of the store RAM, until it finds its place. A record marked final
// then drains the store, one result per cycle, or gives a single empty-status
// result when the store is empty.
// Results appear on rsp_item for one cycle under rsp_strobe, one cycle after
// they are produced, and cannot be held off: the receiver must take every one.
// The store needs no clearing pass after reset; only entries below the count
// are ever read.
`include "filtered_descending_insertion_sort_top_assert.svh"
module filtered_descending_insertion_sort_top import fdis_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_item,
   output logic               rsp_strobe,
   output rsp_type            rsp_item,
   input  logic               csr_wr_en,
   input  logic [GROUP_W-1:0] csr_wr_data
);

   logic [GROUP_W-1:0] wanted_group_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_item_ff;
   evt_type            evt;

   fdis_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_item     (req_item),
      .wanted_group (wanted_group_ff),
      .busy         (busy),
      .evt          (evt)
   );

   // Group register
   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_group_ff <= '0;
      end else if (csr_wr_en) begin
         wanted_group_ff <= csr_wr_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= evt.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= evt.rsp;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   `FDIS_ASSERT_IMPLIES(a_empty_alone, clock, reset, rsp_strobe && rsp_item.status == STATUS_EMPTY, rsp_item.last_result && rsp_item.out_id == '0 && rsp_item.out_score == '0, "empty result malformed")

endmodule
